// ===== src/dhps_pkg.sv =====
// ---------------------------------------------------------------------------
// dhps_pkg: shared types and constants
// Key set with double-hash probing: widths, status codes and beat types.
// ---------------------------------------------------------------------------
package dhps_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned DEPTH    = 1024;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned SIZE_W   = 11;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned BIT_W    = $clog2(KEY_W);

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1021);
  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(3);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(DEPTH);
  localparam logic [6:0]        LOAD_NUM   = 7'd80;
  localparam logic [6:0]        LOAD_DEN   = 7'd100;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd5;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   slot;
  } out_beat_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic              kind;
    logic              bad;
    logic [KEY_W-1:0]  key;
    logic [ADDR_W-1:0] pos;
    logic [ADDR_W-1:0] inc;
    logic [SIZE_W-1:0] size;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_rd_t;

endpackage

// ===== src/dhps_ram.sv =====
// ---------------------------------------------------------------------------
// dhps_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module dhps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/dhps_front.sv =====
// ---------------------------------------------------------------------------
// dhps_front: accept and classify
// Flags zero keys and works out start slot and step by bit-serial remainder.
// ---------------------------------------------------------------------------
module dhps_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_take,
  input  dhps_pkg::in_beat_t            in_data,
  input  logic [dhps_pkg::SIZE_W-1:0]   table_size,
  output logic                          busy,
  output logic                          q_wr,
  output dhps_pkg::item_t               q_item,
  input  logic                          q_full
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t                          state_r, state_nxt;
  logic [dhps_pkg::KEY_W-1:0]       h_r, h_nxt;
  logic [dhps_pkg::BIT_W-1:0]       cnt_r, cnt_nxt;
  logic [dhps_pkg::SIZE_W-1:0]      rem_a_r, rem_a_nxt, rem_b_r, rem_b_nxt;
  logic [dhps_pkg::SIZE_W-1:0]      size_r, size_nxt;
  logic                             kind_r, kind_nxt, bad_r, bad_nxt;
  logic [dhps_pkg::KEY_W-1:0]       key_r, key_nxt;
  logic [dhps_pkg::SIZE_W-1:0]      size_sat, size_m1;
  logic [dhps_pkg::SIZE_W:0]        ta, tb;

  // clamp the size into its legal range
  always_comb begin
    size_sat = table_size;
    if (table_size < dhps_pkg::SIZE_MIN) begin
      size_sat = dhps_pkg::SIZE_MIN;
    end else if (table_size > dhps_pkg::SIZE_MAX) begin
      size_sat = dhps_pkg::SIZE_MAX;
    end
  end

  assign size_m1 = size_r - dhps_pkg::SIZE_W'(1);
  assign ta = {rem_a_r, h_r[cnt_r]};
  assign tb = {rem_b_r, h_r[cnt_r]};

  // sequence: accept, divide one bit a cycle, push
  always_comb begin
    state_nxt = state_r;
    h_nxt     = h_r;
    cnt_nxt   = cnt_r;
    rem_a_nxt = rem_a_r;
    rem_b_nxt = rem_b_r;
    size_nxt  = size_r;
    kind_nxt  = kind_r;
    bad_nxt   = bad_r;
    key_nxt   = key_r;
    case (state_r)
      F_IDLE: begin
        if (in_take) begin
          h_nxt     = in_data.key - dhps_pkg::KEY_W'(1);
          key_nxt   = in_data.key;
          kind_nxt  = in_data.kind;
          size_nxt  = size_sat;
          cnt_nxt   = dhps_pkg::BIT_W'(dhps_pkg::KEY_W - 1);
          rem_a_nxt = '0;
          rem_b_nxt = '0;
          bad_nxt   = (in_data.key == '0);
          state_nxt = (in_data.key == '0) ? F_PUSH : F_DIV;
        end
      end
      F_DIV: begin
        rem_a_nxt = (ta >= {1'b0, size_r}) ? dhps_pkg::SIZE_W'(ta - {1'b0, size_r})
                                          : ta[dhps_pkg::SIZE_W-1:0];
        rem_b_nxt = (tb >= {1'b0, size_m1}) ? dhps_pkg::SIZE_W'(tb - {1'b0, size_m1})
                                           : tb[dhps_pkg::SIZE_W-1:0];
        cnt_nxt   = cnt_r - dhps_pkg::BIT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    h_r     <= h_nxt;
    cnt_r   <= cnt_nxt;
    rem_a_r <= rem_a_nxt;
    rem_b_r <= rem_b_nxt;
    size_r  <= size_nxt;
    kind_r  <= kind_nxt;
    bad_r   <= bad_nxt;
    key_r   <= key_nxt;
  end

  assign busy = (state_r != F_IDLE);
  assign q_wr = (state_r == F_PUSH) && !q_full;

  // build the queue entry
  always_comb begin
    q_item      = '0;
    q_item.kind = kind_r;
    q_item.bad  = bad_r;
    q_item.key  = key_r;
    q_item.size = size_r;
    q_item.pos  = rem_a_r[dhps_pkg::ADDR_W-1:0];
    q_item.inc  = dhps_pkg::ADDR_W'(rem_b_r + dhps_pkg::SIZE_W'(1));
  end

endmodule

// ===== src/dhps_queue.sv =====
// ---------------------------------------------------------------------------
// dhps_queue: two-entry queue
// Decouples the classifying front from the probing back.
// ---------------------------------------------------------------------------
module dhps_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr,
  input  dhps_pkg::item_t   wr_item,
  output logic              full,
  output dhps_pkg::q_rd_t   rd,
  input  logic              pop
);

  dhps_pkg::item_t mem_r [2];
  logic            wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]      cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign rd.valid = (cnt_r != 2'd0);
  assign rd.item  = mem_r[rp_r];

  // advance pointers and count
  always_comb begin
    wp_nxt  = wr ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, wr} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (wr) begin
      mem_r[wp_r] <= wr_item;
    end
  end

endmodule

// ===== src/dhps_back.sv =====
// ---------------------------------------------------------------------------
// dhps_back: probe engine
// Clears the store after reset, walks probe sequences, stores keys, answers.
// ---------------------------------------------------------------------------
module dhps_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dhps_pkg::q_rd_t      rd,
  output logic                 pop,
  output logic                 clearing,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dhps_pkg::out_beat_t  out_data
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_CHECK = 5'b01000,
    S_DONE  = 5'b10000
  } bstate_t;

  bstate_t                           state_r, state_nxt;
  dhps_pkg::item_t                   item_r, item_nxt;
  logic [dhps_pkg::ADDR_W-1:0]       pos_r, pos_nxt, clr_r, clr_nxt;
  logic [dhps_pkg::SIZE_W-1:0]       n_r, n_nxt, cnt_r, cnt_nxt, n_inc, pos_sum;
  logic [dhps_pkg::STATUS_W-1:0]     st_r, st_nxt;
  logic                              ins_r, ins_nxt;
  logic                              ov_r, ov_nxt;
  dhps_pkg::out_beat_t               od_r, od_nxt;
  logic                              we;
  logic [dhps_pkg::ADDR_W-1:0]       waddr;
  logic [dhps_pkg::KEY_W-1:0]        wdata, rdata;
  logic [17:0]                       cap_prod, cnt_prod;
  logic                              is_full, out_free;

  dhps_ram #(.WIDTH(dhps_pkg::KEY_W), .DEPTH(dhps_pkg::DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (pos_r),
    .rdata (rdata)
  );

  assign cap_prod = 18'(item_r.size) * 18'(dhps_pkg::LOAD_NUM);
  assign cnt_prod = 18'(cnt_r) * 18'(dhps_pkg::LOAD_DEN);
  assign is_full  = (cap_prod <= cnt_prod);
  assign n_inc    = n_r + dhps_pkg::SIZE_W'(1);
  assign pos_sum  = dhps_pkg::SIZE_W'(pos_r) + dhps_pkg::SIZE_W'(item_r.inc);
  assign out_free = !ov_r || !out_stall;

  // probe sequencer
  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    pos_nxt   = pos_r;
    clr_nxt   = clr_r;
    n_nxt     = n_r;
    cnt_nxt   = cnt_r;
    st_nxt    = st_r;
    ins_nxt   = ins_r;
    ov_nxt    = ov_r && out_stall;
    od_nxt    = od_r;
    pop       = 1'b0;
    we        = 1'b0;
    waddr     = pos_r;
    wdata     = item_r.key;
    case (state_r)
      S_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = '0;
        clr_nxt = clr_r + dhps_pkg::ADDR_W'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (rd.valid) begin
          pop      = 1'b1;
          item_nxt = rd.item;
          pos_nxt  = rd.item.pos;
          n_nxt    = '0;
          ins_nxt  = 1'b0;
          if (rd.item.bad) begin
            st_nxt    = dhps_pkg::ST_INVALID;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = S_DONE;
        if (rdata == '0) begin
          if (item_r.kind == dhps_pkg::KIND_LOOKUP) begin
            st_nxt = dhps_pkg::ST_NOT_FOUND;
          end else if (is_full) begin
            st_nxt = dhps_pkg::ST_FULL;
          end else begin
            st_nxt  = dhps_pkg::ST_INSERTED;
            ins_nxt = 1'b1;
          end
        end else if (rdata == item_r.key) begin
          st_nxt = (item_r.kind == dhps_pkg::KIND_LOOKUP) ? dhps_pkg::ST_FOUND
                                                          : dhps_pkg::ST_PRESENT;
        end else if (n_inc == item_r.size) begin
          st_nxt = (item_r.kind == dhps_pkg::KIND_LOOKUP) ? dhps_pkg::ST_NOT_FOUND
                                                          : dhps_pkg::ST_FULL;
        end else begin
          n_nxt     = n_inc;
          pos_nxt   = (pos_sum >= item_r.size)
                      ? dhps_pkg::ADDR_W'(pos_sum - item_r.size)
                      : pos_sum[dhps_pkg::ADDR_W-1:0];
          state_nxt = S_READ;
        end
      end
      S_DONE: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          od_nxt.status = st_r;
          od_nxt.slot   = (st_r == dhps_pkg::ST_INSERTED || st_r == dhps_pkg::ST_PRESENT ||
                           st_r == dhps_pkg::ST_FOUND) ? pos_r : '0;
          if (ins_r) begin
            we      = 1'b1;
            cnt_nxt = cnt_r + dhps_pkg::SIZE_W'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
    item_r <= item_nxt;
    pos_r  <= pos_nxt;
    n_r    <= n_nxt;
    st_r   <= st_nxt;
    ins_r  <= ins_nxt;
    od_r   <= od_nxt;
  end

  assign clearing  = (state_r == S_CLEAR);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("probe state not one-hot");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= dhps_pkg::SIZE_MAX) else $error("entry count beyond depth");

  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == S_CLEAR || (state_r == S_DONE && ins_r)))
    else $error("store written outside clear or insert");

  a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHECK |-> dhps_pkg::SIZE_W'(pos_r) < item_r.size)
    else $error("probe slot outside table");

endmodule

// ===== src/double_hash_pointer_set_top.sv =====
// ---------------------------------------------------------------------------
// double_hash_pointer_set_top: double-hash key set
// Path: a taken beat goes through the front (32 remainder steps and a push), the
// two-entry queue and the back (pop, then a read and a check per probe) to a registered result.
// The front takes no new beat until it has pushed the last one; the bit-serial remainder
// limits the rate, and the one-read-port store does so on longer chains.
// Reset: synchronous; after reset a clearing pass over all 1024 slots stalls input.
// ---------------------------------------------------------------------------
module double_hash_pointer_set_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  dhps_pkg::in_beat_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output dhps_pkg::out_beat_t          out_data,
  input  logic                         cfg_we,
  input  logic [dhps_pkg::SIZE_W-1:0]  cfg_wdata
);

  logic [dhps_pkg::SIZE_W-1:0] table_size_r, table_size_nxt;
  logic                        fr_busy, clearing, q_wr, q_full, pop;
  dhps_pkg::item_t             q_item;
  dhps_pkg::q_rd_t             q_rd;

  // hold the size register
  assign table_size_nxt = cfg_we ? cfg_wdata : table_size_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= dhps_pkg::SIZE_RESET;
    end else begin
      table_size_r <= table_size_nxt;
    end
  end

  assign in_stall = fr_busy || clearing;

  dhps_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_take    (in_valid && !in_stall),
    .in_data    (in_data),
    .table_size (table_size_r),
    .busy       (fr_busy),
    .q_wr       (q_wr),
    .q_item     (q_item),
    .q_full     (q_full)
  );

  dhps_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_item (q_item),
    .full    (q_full),
    .rd      (q_rd),
    .pop     (pop)
  );

  dhps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd        (q_rd),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/double_hash_pointer_set_top_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// double_hash_pointer_set_top_tb: self-checking bench for the double-hash key set
// Drives inserts and lookups through the valid/stall channels. A scoreboard
// keeps its own copy of the table, predicts every result and checks it in
// order. The table size is changed between phases, including values that
// saturate and sizes that are not prime. Both sides idle and stall at random.
// ---------------------------------------------------------------------------
module double_hash_pointer_set_top_tb;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES    = 2000;
  localparam int unsigned DRAIN_CYCLES   = 100;
  localparam int unsigned PHASE_ITEMS    = 140;
  localparam logic [dhps_pkg::SIZE_W-1:0] PHASE_SIZES [10] = '{
    11'd2, 11'd4, 11'd6, 11'd13, 11'd0, 11'd97, 11'd2047, 11'd1021, 11'd3, 11'd1024};

  // Scoreboard: private copy of the key table and queue of expected beats
  class key_set_scoreboard;
    logic [dhps_pkg::KEY_W-1:0]  slots [dhps_pkg::DEPTH];
    int unsigned                 entries;
    logic [dhps_pkg::SIZE_W-1:0] size_reg;
    dhps_pkg::out_beat_t         expected_q [$];
    int unsigned                 errors;
    int unsigned                 status_seen [6];

    function new();
      foreach (slots[i]) slots[i] = '0;
      entries  = 0;
      size_reg = dhps_pkg::SIZE_RESET;
      errors   = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function dhps_pkg::out_beat_t lookup_or_store(dhps_pkg::in_beat_t b);
      dhps_pkg::out_beat_t        r;
      int unsigned                sz, pos, inc, n;
      logic [dhps_pkg::KEY_W-1:0] h;
      bit                         hit, has_empty;
      r.status = dhps_pkg::ST_INVALID;
      r.slot   = '0;
      sz = size_reg;
      if (sz < dhps_pkg::SIZE_MIN) sz = dhps_pkg::SIZE_MIN;
      if (sz > dhps_pkg::SIZE_MAX) sz = dhps_pkg::SIZE_MAX;
      if (b.key == '0) return r;
      h   = b.key - 1;
      pos = h % sz;
      inc = 1 + h % (sz - 1);
      hit = 0;
      has_empty = 0;
      // walk the probe chain, at most as many probes as the table has slots
      for (n = 0; n < sz; n++) begin
        if (slots[pos] == '0) begin
          has_empty = 1;
          break;
        end
        if (slots[pos] == b.key) begin
          hit = 1;
          break;
        end
        pos = (pos + inc) % sz;
      end
      if (hit) begin
        r.status = (b.kind == dhps_pkg::KIND_INSERT) ? dhps_pkg::ST_PRESENT
                                                     : dhps_pkg::ST_FOUND;
        r.slot   = dhps_pkg::ADDR_W'(pos);
      end else if (b.kind == dhps_pkg::KIND_LOOKUP) begin
        r.status = dhps_pkg::ST_NOT_FOUND;
      end else if (sz * 80 <= entries * 100 || !has_empty) begin
        r.status = dhps_pkg::ST_FULL;
      end else begin
        slots[pos] = b.key;
        entries    = (entries + 1) & 11'h7FF;
        r.status   = dhps_pkg::ST_INSERTED;
        r.slot     = dhps_pkg::ADDR_W'(pos);
      end
      return r;
    endfunction

    function void note_input(dhps_pkg::in_beat_t b);
      expected_q.push_back(lookup_or_store(b));
    endfunction

    function void check_result(dhps_pkg::out_beat_t r);
      dhps_pkg::out_beat_t e;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: status %0d slot %0d", r.status, r.slot);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (r.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, r.status);
        errors++;
      end
      if (r.slot !== e.slot) begin
        $error("slot: expected %0d, got %0d", e.slot, r.slot);
        errors++;
      end
      if (e.status <= dhps_pkg::ST_INVALID) status_seen[e.status]++;
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  dhps_pkg::in_beat_t          in_data;
  logic                        out_valid;
  logic                        out_stall;
  dhps_pkg::out_beat_t         out_data;
  logic                        cfg_we;
  logic [dhps_pkg::SIZE_W-1:0] cfg_wdata;

  key_set_scoreboard           sb;
  int unsigned                 send_idle_pct;
  int unsigned                 recv_stall_pct;
  int unsigned                 hold_cnt;
  int unsigned                 quiet_cycles;
  int unsigned                 items_sent;
  logic [dhps_pkg::KEY_W-1:0]  key_pool [$];

  double_hash_pointer_set_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt  = hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Check each accepted result beat
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Watchdog: count cycles with no beat accepted on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired after %0d quiet cycles", quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Offer one beat after random idle cycles; hold it until accepted
  task automatic send_beat(input logic kind, input logic [dhps_pkg::KEY_W-1:0] key);
    dhps_pkg::in_beat_t b;
    b.kind = kind;
    b.key  = key;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    sb.note_input(b);
    items_sent++;
    if (kind == dhps_pkg::KIND_INSERT && key != '0 && key_pool.size() < 400)
      key_pool.push_back(key);
  endtask

  // Drain all results, let the block settle, then write the table size
  task automatic write_size(input logic [dhps_pkg::SIZE_W-1:0] value);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.size_reg = value;
  endtask

  // Random item: mostly keys already inserted or fresh, with a few zeros
  task automatic send_random();
    logic                       kind;
    logic [dhps_pkg::KEY_W-1:0] key;
    int unsigned                pick;
    kind = ($urandom_range(99) < 50) ? dhps_pkg::KIND_INSERT : dhps_pkg::KIND_LOOKUP;
    pick = $urandom_range(99);
    if (pick < 3)
      key = '0;
    else if (pick < 45 && key_pool.size() > 0)
      key = key_pool[$urandom_range(key_pool.size() - 1)];
    else
      key = $urandom;
    send_beat(kind, key);
  endtask

  initial begin
    sb             = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cnt       = 0;
    quiet_cycles   = 0;
    items_sent     = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero key, extreme keys, duplicates and a collision chain
    send_beat(dhps_pkg::KIND_INSERT, 32'h0);
    send_beat(dhps_pkg::KIND_LOOKUP, 32'h0);
    send_beat(dhps_pkg::KIND_LOOKUP, 32'h1);
    send_beat(dhps_pkg::KIND_INSERT, 32'h1);
    send_beat(dhps_pkg::KIND_INSERT, 32'h1);
    send_beat(dhps_pkg::KIND_LOOKUP, 32'h1);
    send_beat(dhps_pkg::KIND_INSERT, 32'hFFFF_FFFF);
    send_beat(dhps_pkg::KIND_LOOKUP, 32'hFFFF_FFFF);
    send_beat(dhps_pkg::KIND_INSERT, 32'd1022);
    send_beat(dhps_pkg::KIND_INSERT, 32'd2043);
    send_beat(dhps_pkg::KIND_LOOKUP, 32'd2043);
    send_beat(dhps_pkg::KIND_LOOKUP, 32'd3064);
    send_beat(dhps_pkg::KIND_INSERT, 32'h8000_0000);
    send_beat(dhps_pkg::KIND_LOOKUP, 32'h7FFF_FFFF);

    // Random phases over sizes, idle patterns and stall patterns
    for (int p = 0; p < 10; p++) begin
      write_size(PHASE_SIZES[p]);
      case (p % 4)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 60; recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 60;
        end
        default: begin
          send_idle_pct = 24; recv_stall_pct = 24;
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // fill the block against a long receiver hold-off
        if (p == 5 && i == 10) hold_cnt = HOLD_CYCLES;
        send_random();
      end
    end

    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d items over 11 table sizes with 4 idle patterns and a hold-off",
             items_sent);
    $display("inserted %0d, present %0d, found %0d, not found %0d, full %0d, invalid %0d",
             sb.status_seen[dhps_pkg::ST_INSERTED], sb.status_seen[dhps_pkg::ST_PRESENT],
             sb.status_seen[dhps_pkg::ST_FOUND], sb.status_seen[dhps_pkg::ST_NOT_FOUND],
             sb.status_seen[dhps_pkg::ST_FULL], sb.status_seen[dhps_pkg::ST_INVALID]);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
